FILE: rtl/core/itar_pkg.sv
// itar_pkg: shared constants, types and the digit encoder for the radix converter
// used by every file of integer_to_ascii_radix; depends on nothing

package itar_pkg;

    // default sizing of the block
    localparam int MAX_PRECISION_DEF = 32;
    localparam int VALUE_BITS_DEF    = 32;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // divider retires this many dividend bits per cycle
    localparam int DIV_BITS = 4;

    // mode flag bit positions
    localparam int FLAG_LOWER_BIT  = 0;
    localparam int FLAG_SIGNED_BIT = 1;

    // legal radix range
    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;

    // ascii codes
    localparam logic [6:0] CH_MINUS   = 7'h2D;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_NINE    = 7'h39;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_UPPER_F = 7'h46;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_F = 7'h66;

    typedef struct packed {
        logic       neg;
        logic       lower;
        logic [4:0] base;
    } t_job_flags;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic lower);
        logic [6:0] res;
        if (d < 4'd10) begin
            res = CH_ZERO + 7'(d);
        end else if (lower) begin
            res = CH_LOWER_A + 7'(d) - 7'd10;
        end else begin
            res = CH_UPPER_A + 7'(d) - 7'd10;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/itar_front.sv
// itar_front: accepts numbers, checks the radix, takes the magnitude and clamps precision
// uses itar_pkg; feeds itar_queue

module itar_front #(
    parameter int MAX_PRECISION = itar_pkg::MAX_PRECISION_DEF,
    parameter int VALUE_BITS    = itar_pkg::VALUE_BITS_DEF,
    localparam int PW           = $clog2(MAX_PRECISION + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_value,
    input  logic [4:0]            i_base,
    input  logic [5:0]            i_precision,
    input  logic [1:0]            i_mode_flags,
    output logic                  o_push,
    input  logic                  i_full,
    output itar_pkg::t_job_flags  o_flags,
    output logic [VALUE_BITS-1:0] o_mag,
    output logic [PW-1:0]         o_prec
);

    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  keep;
    logic [PW-1:0]         prec_sat;
    logic                  take;
    logic                  leave;

    logic                  r_vld;
    logic                  r_keep;
    itar_pkg::t_job_flags  r_flags;
    logic [VALUE_BITS-1:0] r_mag;
    logic [PW-1:0]         r_prec;

    always_comb begin
        v    = VALUE_BITS'(i_value);
        neg  = i_mode_flags[itar_pkg::FLAG_SIGNED_BIT] && v[VALUE_BITS-1];
        mag  = neg ? (~v + 1'b1) : v;
        prec_sat = (8'(i_precision) > 8'(MAX_PRECISION)) ? PW'(MAX_PRECISION)
                                                         : PW'(i_precision);
        // bad radix, or zero with no precision, prints nothing
        keep = (i_base >= itar_pkg::BASE_MIN) && (i_base <= itar_pkg::BASE_MAX)
               && !((v == '0) && (i_precision == 6'd0));
    end

    assign leave   = r_vld && (!r_keep || !i_full);
    assign o_stall = r_vld && r_keep && i_full;
    assign take    = i_valid && !o_stall;
    assign o_push  = r_vld && r_keep && !i_full;
    assign o_flags = r_flags;
    assign o_mag   = r_mag;
    assign o_prec  = r_prec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (take) begin
                r_vld <= 1'b1;
            end else if (leave) begin
                r_vld <= 1'b0;
            end
        end
        if (take) begin
            r_keep        <= keep;
            r_flags.neg   <= neg;
            r_flags.lower <= i_mode_flags[itar_pkg::FLAG_LOWER_BIT];
            r_flags.base  <= i_base;
            r_mag         <= mag;
            r_prec        <= prec_sat;
        end
    end

endmodule

FILE: rtl/core/itar_queue.sv
// itar_queue: small register fifo holding classified jobs between front and back
// uses itar_pkg for its default depth

module itar_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = itar_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

FILE: rtl/core/itar_back.sv
// itar_back: splits the magnitude into digits with a shared iterative divider,
// keeps them in a digit memory and streams sign, padding and digits; uses itar_pkg

module itar_back #(
    parameter int MAX_PRECISION = itar_pkg::MAX_PRECISION_DEF,
    parameter int VALUE_BITS    = itar_pkg::VALUE_BITS_DEF,
    localparam int PW           = $clog2(MAX_PRECISION + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_vld,
    output logic                  o_pop,
    input  itar_pkg::t_job_flags  i_flags,
    input  logic [VALUE_BITS-1:0] i_mag,
    input  logic [PW-1:0]         i_prec,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [6:0]            o_character,
    output logic                  o_last
);

    localparam int DIV_STEPS = (VALUE_BITS + itar_pkg::DIV_BITS - 1) / itar_pkg::DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * itar_pkg::DIV_BITS;
    localparam int SW        = $clog2(DIV_STEPS);
    localparam int IW        = $clog2(VALUE_BITS);
    localparam int CW        = $clog2(VALUE_BITS + 1);
    localparam int PADW      = (PW > CW) ? PW : CW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_SIGN,
        S_PAD,
        S_DIGIT
    } t_state;

    t_state               r_state;
    itar_pkg::t_job_flags r_flags;
    logic [DIV_W-1:0]     r_quot;
    logic [3:0]           r_rem;
    logic [SW-1:0]        r_step;
    logic [CW-1:0]        r_ndig;
    logic [PW-1:0]        r_prec;
    logic [PADW-1:0]      r_pad;
    logic                 r_have_dig;
    logic [3:0]           r_rd;
    logic                 r_ovld;
    logic [6:0]           r_char;
    logic                 r_last;
    logic [3:0]           r_dig_mem [VALUE_BITS];

    logic [DIV_W-1:0]     q_nx;
    logic [3:0]           rem_nx;
    logic [4:0]           t;
    logic                 out_free;
    logic                 char_go;
    logic                 div_go;
    logic                 dig_wr;
    logic                 dig_rd;
    logic [CW-1:0]        ndig_dec;
    logic [PADW-1:0]      prec_ext;
    logic [PADW-1:0]      ndig_ext;
    logic                 need_pad;

    // restoring division, a few dividend bits per cycle; quotient shifts in from the bottom
    always_comb begin
        q_nx   = r_quot;
        rem_nx = r_rem;
        t      = '0;
        for (int k = 0; k < itar_pkg::DIV_BITS; k++) begin
            t    = {rem_nx, q_nx[DIV_W-1]};
            q_nx = {q_nx[DIV_W-2:0], 1'b0};
            if (t >= r_flags.base) begin
                t       = t - r_flags.base;
                q_nx[0] = 1'b1;
            end
            rem_nx = t[3:0];
        end
    end

    always_comb begin
        out_free = !r_ovld || !i_stall;
        // the streaming states put out one character whenever the output is free
        char_go  = out_free && ((r_state == S_SIGN) || (r_state == S_PAD)
                                || (r_state == S_DIGIT));
        o_pop    = (r_state == S_IDLE) && i_job_vld;
        div_go   = (r_state == S_DIV) && !((r_step == '0) && (r_quot == '0));
        dig_wr   = div_go && (r_step == SW'(DIV_STEPS - 1));
        ndig_dec = r_ndig - 1'b1;
        dig_rd   = (r_ndig != '0)
                   && ((r_state == S_PREP) || ((r_state == S_DIGIT) && out_free));
        prec_ext = PADW'(r_prec);
        ndig_ext = PADW'(r_ndig);
        need_pad = prec_ext > ndig_ext;
    end

    assign o_valid     = r_ovld;
    assign o_character = r_char;
    assign o_last      = r_last;

    // digit store, least significant digit at address zero
    always_ff @(posedge i_clk) begin
        if (dig_wr) begin
            r_dig_mem[r_ndig[IW-1:0]] <= rem_nx;
        end
        if (dig_rd) begin
            r_rd <= r_dig_mem[ndig_dec[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            if (out_free) begin
                r_ovld <= char_go;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_vld) begin
                        r_flags <= i_flags;
                        r_quot  <= DIV_W'(i_mag);
                        r_prec  <= i_prec;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_ndig  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!div_go) begin
                        r_state <= S_PREP;
                    end else begin
                        r_quot <= q_nx;
                        if (dig_wr) begin
                            r_rem  <= '0;
                            r_step <= '0;
                            r_ndig <= r_ndig + 1'b1;
                        end else begin
                            r_rem  <= rem_nx;
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                S_PREP: begin
                    // first digit is fetched here so it is ready after sign and padding
                    r_pad      <= need_pad ? (prec_ext - ndig_ext) : '0;
                    r_have_dig <= (r_ndig != '0);
                    if (r_ndig != '0) begin
                        r_ndig <= ndig_dec;
                    end
                    if (r_flags.neg) begin
                        r_state <= S_SIGN;
                    end else if (need_pad) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_DIGIT;
                    end
                end
                S_SIGN: begin
                    if (out_free) begin
                        r_char  <= itar_pkg::CH_MINUS;
                        r_last  <= 1'b0;
                        r_state <= (r_pad != '0) ? S_PAD : S_DIGIT;
                    end
                end
                S_PAD: begin
                    if (out_free) begin
                        r_char <= itar_pkg::CH_ZERO;
                        r_last <= (r_pad == PADW'(1)) && !r_have_dig;
                        r_pad  <= r_pad - 1'b1;
                        if (r_pad == PADW'(1)) begin
                            r_state <= r_have_dig ? S_DIGIT : S_IDLE;
                        end
                    end
                end
                S_DIGIT: begin
                    if (out_free) begin
                        r_char <= itar_pkg::digit_char(r_rd, r_flags.lower);
                        r_last <= (r_ndig == '0);
                        if (r_ndig == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ndig <= ndig_dec;
                        end
                    end
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/integer_to_ascii_radix.sv
// integer_to_ascii_radix: top level of the integer to ascii converter
// instantiates itar_front, itar_queue and itar_back; uses itar_pkg

// Converts one number per transfer into its ascii text, one character per output
// transfer, most significant first, with o_last on the final character. The front
// stage registers a number and hands it through a two-entry job queue, so it keeps
// accepting while the back end works, until the queue is full. The back end takes
// one number at a time: the shared divider retires four dividend bits per cycle to
// produce each digit, then characters stream at one per cycle while the output is
// not stalled. A bad radix, or zero with precision zero, produces no characters.

module integer_to_ascii_radix #(
    parameter int MAX_PRECISION = itar_pkg::MAX_PRECISION_DEF,
    parameter int VALUE_BITS    = itar_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    input  logic [4:0]  i_base,
    input  logic [5:0]  i_precision,
    input  logic [1:0]  i_mode_flags,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_character,
    output logic        o_last
);

    localparam int PW      = $clog2(MAX_PRECISION + 1);
    localparam int FLAGS_W = $bits(itar_pkg::t_job_flags);
    localparam int QW      = FLAGS_W + VALUE_BITS + PW;

    logic                  f_push;
    itar_pkg::t_job_flags  f_flags;
    logic [VALUE_BITS-1:0] f_mag;
    logic [PW-1:0]         f_prec;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic [QW-1:0]         q_wdata;
    logic [QW-1:0]         q_rdata;
    itar_pkg::t_job_flags  b_flags;
    logic [VALUE_BITS-1:0] b_mag;
    logic [PW-1:0]         b_prec;

    assign q_wdata = {f_flags, f_mag, f_prec};
    assign b_flags = itar_pkg::t_job_flags'(q_rdata[QW-1 -: FLAGS_W]);
    assign b_mag   = q_rdata[PW +: VALUE_BITS];
    assign b_prec  = q_rdata[PW-1:0];

    itar_front #(
        .MAX_PRECISION (MAX_PRECISION),
        .VALUE_BITS    (VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_base       (i_base),
        .i_precision  (i_precision),
        .i_mode_flags (i_mode_flags),
        .o_push       (f_push),
        .i_full       (q_full),
        .o_flags      (f_flags),
        .o_mag        (f_mag),
        .o_prec       (f_prec)
    );

    itar_queue #(
        .WIDTH (QW),
        .DEPTH (itar_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    itar_back #(
        .MAX_PRECISION (MAX_PRECISION),
        .VALUE_BITS    (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_vld   (!q_empty),
        .o_pop       (q_pop),
        .i_flags     (b_flags),
        .i_mag       (b_mag),
        .i_prec      (b_prec),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

FILE: rtl/core/itar_checker.sv
// itar_checker: port-level checks on the character output of integer_to_ascii_radix
// uses itar_pkg; bound to the top level at the end of this file

module itar_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_character,
    input logic       o_last
);

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("stalled character changed");

    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == itar_pkg::CH_MINUS)
            || ((o_character >= itar_pkg::CH_ZERO) && (o_character <= itar_pkg::CH_NINE))
            || ((o_character >= itar_pkg::CH_UPPER_A)
                && (o_character <= itar_pkg::CH_UPPER_F))
            || ((o_character >= itar_pkg::CH_LOWER_A)
                && (o_character <= itar_pkg::CH_LOWER_F)))
        else $error("character outside the digit set");

    // a minus sign is always followed by at least one digit
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == itar_pkg::CH_MINUS) |-> !o_last)
        else $error("minus sign flagged as last character");

endmodule

bind integer_to_ascii_radix itar_checker u_itar_checker (.*);

FILE: tb/tb_integer_to_ascii_radix.sv
// tb_integer_to_ascii_radix: self-checking bench for the integer to ascii converter
// predicts the character stream of each number and checks it against o_character/o_last
// depends on itar_pkg and integer_to_ascii_radix

module tb_integer_to_ascii_radix;

    localparam int MAX_PREC     = itar_pkg::MAX_PRECISION_DEF;
    localparam int N_RANDOM     = 205;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 400;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int MAX_REPORTS  = 50;

    localparam logic [1:0] MODE_UPPER        = 2'b00;
    localparam logic [1:0] MODE_LOWER        = 2'(1 << itar_pkg::FLAG_LOWER_BIT);
    localparam logic [1:0] MODE_SIGNED       = 2'(1 << itar_pkg::FLAG_SIGNED_BIT);
    localparam logic [1:0] MODE_SIGNED_LOWER = MODE_LOWER | MODE_SIGNED;

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  base;
        logic [5:0]  precision;
        logic [1:0]  mode_flags;
    } t_number_req;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_char_beat;

    class char_scoreboard;
        t_char_beat expected_chars[$];
        int         n_errors;

        function new();
            n_errors = 0;
        endfunction

        task report(string msg);
            if (n_errors < MAX_REPORTS) begin
                $display("ERROR: %s", msg);
            end
            n_errors++;
        endtask

        // works out the text of one number and queues it
        function void note_number(t_number_req r);
            logic [31:0] mag;
            logic [3:0]  digs [0:31];
            int          ndig;
            int          prec;
            logic        neg;
            string       digit_set;
            t_char_beat  text[$];
            ndig = 0;
            if (r.base < itar_pkg::BASE_MIN || r.base > itar_pkg::BASE_MAX) begin
                return;
            end
            prec = (r.precision > MAX_PREC) ? MAX_PREC : int'(r.precision);
            digit_set = r.mode_flags[itar_pkg::FLAG_LOWER_BIT] ? "0123456789abcdef"
                                                               : "0123456789ABCDEF";
            neg = r.mode_flags[itar_pkg::FLAG_SIGNED_BIT] && r.value[31];
            mag = neg ? (~r.value + 32'd1) : r.value;
            if (neg) begin
                text.push_back(t_char_beat'{itar_pkg::CH_MINUS, 1'b0});
            end
            while (mag != 32'd0) begin
                digs[ndig] = 4'(mag % r.base);
                mag = mag / r.base;
                ndig++;
            end
            for (int i = ndig; i < prec; i++) begin
                text.push_back(t_char_beat'{itar_pkg::CH_ZERO, 1'b0});
            end
            for (int i = ndig - 1; i >= 0; i--) begin
                text.push_back(t_char_beat'{7'(digit_set[digs[i]]), 1'b0});
            end
            if (text.size() > 0) begin
                text[text.size() - 1].last = 1'b1;
            end
            foreach (text[i]) begin
                expected_chars.push_back(text[i]);
            end
        endfunction

        task check_char(logic [6:0] ch, logic last);
            t_char_beat exp_beat;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected character 0x%02h last=%0b", ch, last));
                return;
            end
            exp_beat = expected_chars.pop_front();
            if (ch !== exp_beat.character) begin
                report($sformatf("character 0x%02h ('%c'), expected 0x%02h ('%c')",
                                 ch, ch, exp_beat.character, exp_beat.character));
            end
            if (last !== exp_beat.last) begin
                report($sformatf("last=%0b on character 0x%02h, expected %0b",
                                 last, ch, exp_beat.last));
            end
        endtask

        task check_leftover();
            if (expected_chars.size() != 0) begin
                report($sformatf("%0d expected characters never arrived",
                                 expected_chars.size()));
            end
        endtask

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_value;
    logic [4:0]  i_base;
    logic [5:0]  i_precision;
    logic [1:0]  i_mode_flags;
    logic        o_valid;
    logic        i_stall;
    logic [6:0]  o_character;
    logic        o_last;

    char_scoreboard sb;
    int             n_taken;

    integer_to_ascii_radix dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_base       (i_base),
        .i_precision  (i_precision),
        .i_mode_flags (i_mode_flags),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_character  (o_character),
        .o_last       (o_last)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // both transfers are sampled on the same edge, input first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_number(t_number_req'{i_value, i_base, i_precision, i_mode_flags});
                n_taken++;
            end
            if ($isunknown(o_valid)) begin
                sb.report("o_valid is unknown");
            end else if (o_valid && !i_stall) begin
                sb.check_char(o_character, o_last);
            end
        end
    end

    function automatic t_number_req mk_number(logic [31:0] value, logic [4:0] base,
                                              logic [5:0] precision, logic [1:0] mode);
        t_number_req r;
        r.value      = value;
        r.base       = base;
        r.precision  = precision;
        r.mode_flags = mode;
        return r;
    endfunction

    function automatic t_number_req rand_number();
        t_number_req r;
        int          pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3, 4: r.value = $urandom;
            5: r.value = $urandom_range(0, 300);
            6: begin
                case ($urandom_range(0, 4))
                    0: r.value = 32'h0000_0000;
                    1: r.value = 32'h0000_0001;
                    2: r.value = 32'hFFFF_FFFF;
                    3: r.value = 32'h8000_0000;
                    default: r.value = 32'h7FFF_FFFF;
                endcase
            end
            7: r.value = -32'($urandom_range(1, 1000));
            8: begin
                r.value = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1)) begin
                    r.value = ~r.value;
                end
            end
            default: r.value = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 19) < 18) begin
            r.base = 5'($urandom_range(itar_pkg::BASE_MIN, itar_pkg::BASE_MAX));
        end else if ($urandom_range(0, 1)) begin
            r.base = 5'($urandom_range(0, itar_pkg::BASE_MIN - 1));
        end else begin
            r.base = 5'($urandom_range(itar_pkg::BASE_MAX + 1, 31));
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            r.precision = 6'($urandom_range(0, 4));
        end else if (pick < 8) begin
            r.precision = 6'($urandom_range(5, 16));
        end else if (pick < 9) begin
            r.precision = 6'($urandom_range(17, MAX_PREC));
        end else begin
            r.precision = 6'($urandom_range(MAX_PREC + 1, 63));
        end
        r.mode_flags = 2'($urandom_range(0, 3));
        return r;
    endfunction

    // holds the payload until the block takes it
    task automatic send_number(input t_number_req r);
        i_valid      <= 1'b1;
        i_value      <= r.value;
        i_base       <= r.base;
        i_precision  <= r.precision;
        i_mode_flags <= r.mode_flags;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            n = 0;
        end else if (pick < 17) begin
            n = $urandom_range(1, 3);
        end else if (pick < 19) begin
            n = $urandom_range(4, 12);
        end else begin
            n = $urandom_range(25, 70);
        end
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin : receiver
        int  run_len;
        int  pick;
        bit  held_long;
        held_long = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held_long && n_taken >= 40) begin
                // long hold-off so the job queue fills and the input stalls
                held_long = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 11) begin
                    i_stall <= 1'b0;
                    run_len = $urandom_range(1, 8);
                end else if (pick < 12) begin
                    i_stall <= 1'b0;
                    run_len = $urandom_range(40, 120);
                end else if (pick < 18) begin
                    i_stall <= 1'b1;
                    run_len = $urandom_range(1, 3);
                end else begin
                    i_stall <= 1'b1;
                    run_len = $urandom_range(10, 30);
                end
                repeat (run_len) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_number_req plan[$];
        sb = new();
        n_taken = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_value      <= '0;
        i_base       <= '0;
        i_precision  <= '0;
        i_mode_flags <= MODE_UPPER;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero with no precision, zero padding, full width
        plan.push_back(mk_number(32'h0000_0000, 5'd10, 6'd0,  MODE_UPPER));
        plan.push_back(mk_number(32'h0000_0000, 5'd10, 6'd1,  MODE_SIGNED));
        plan.push_back(mk_number(32'h0000_0000, 5'd2,  6'd32, MODE_UPPER));
        plan.push_back(mk_number(32'hFFFF_FFFF, 5'd2,  6'd0,  MODE_UPPER));
        plan.push_back(mk_number(32'hFFFF_FFFF, 5'd2,  6'd0,  MODE_SIGNED));
        // most negative number, longest output
        plan.push_back(mk_number(32'h8000_0000, 5'd2,  6'd0,  MODE_SIGNED));
        plan.push_back(mk_number(32'h8000_0000, 5'd10, 6'd0,  MODE_SIGNED));
        plan.push_back(mk_number(32'h8000_0000, 5'd16, 6'd0,  MODE_UPPER));
        plan.push_back(mk_number(32'h7FFF_FFFF, 5'd10, 6'd0,  MODE_SIGNED_LOWER));
        plan.push_back(mk_number(32'hDEAD_BEEF, 5'd16, 6'd0,  MODE_UPPER));
        plan.push_back(mk_number(32'hDEAD_BEEF, 5'd16, 6'd0,  MODE_LOWER));
        plan.push_back(mk_number(32'hFFFF_FFFF, 5'd16, 6'd8,  MODE_LOWER));
        plan.push_back(mk_number(32'hFFFF_FFFF, 5'd10, 6'd0,  MODE_UPPER));
        // radix out of range
        plan.push_back(mk_number(32'h0000_1234, 5'd0,  6'd4,  MODE_UPPER));
        plan.push_back(mk_number(32'h0000_1234, 5'd1,  6'd0,  MODE_SIGNED));
        plan.push_back(mk_number(32'h0000_1234, 5'd17, 6'd0,  MODE_LOWER));
        plan.push_back(mk_number(32'hFFFF_FFFF, 5'd31, 6'd63, MODE_SIGNED_LOWER));
        // odd radixes
        plan.push_back(mk_number(32'hFFFF_FFFF, 5'd3,  6'd0,  MODE_UPPER));
        plan.push_back(mk_number(32'd123456789, 5'd7,  6'd0,  MODE_UPPER));
        plan.push_back(mk_number(32'hCAFE_F00D, 5'd15, 6'd0,  MODE_LOWER));
        // precision saturates, padding after the sign
        plan.push_back(mk_number(32'd5,         5'd10, 6'd63, MODE_UPPER));
        plan.push_back(mk_number(32'd1,         5'd2,  6'd33, MODE_UPPER));
        plan.push_back(mk_number(-32'd5,        5'd10, 6'd4,  MODE_SIGNED));
        plan.push_back(mk_number(-32'd171,      5'd16, 6'd5,  MODE_SIGNED_LOWER));

        foreach (plan[k]) begin
            send_number(plan[k]);
            idle_gap();
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            send_number(rand_number());
            // every fourth block of 20 numbers goes back to back
            if ((k / 20) % 4 != 3) begin
                idle_gap();
            end
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_leftover();
        if (sb.n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: integer_to_ascii_radix.f
rtl/core/itar_pkg.sv
rtl/core/itar_front.sv
rtl/core/itar_queue.sv
rtl/core/itar_back.sv
rtl/core/integer_to_ascii_radix.sv
rtl/core/itar_checker.sv
tb/tb_integer_to_ascii_radix.sv
